// ----- hw/rtl/aoe_cfe_pkg.sv -----
`default_nettype none

package aoe_cfe_pkg;

  localparam int SLOT_COUNT_DEF = 16;

  // Configuration port geometry: 64-bit registers at 8-byte spacing.
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 5;

  localparam logic [1:0] REG_CAPACITY = 2'd0;
  localparam logic [1:0] REG_SHELF    = 2'd1;
  localparam logic [1:0] REG_SLOT     = 2'd2;

  localparam logic [7:0] OP_READ      = 8'h20;
  localparam logic [7:0] OP_READ_EXT  = 8'h24;
  localparam logic [7:0] OP_WRITE     = 8'h30;
  localparam logic [7:0] OP_WRITE_EXT = 8'h34;
  localparam logic [7:0] OP_IDENTIFY  = 8'hEC;
  localparam logic [7:0] OP_FLUSH     = 8'hE7;

  localparam logic [15:0] WILD_SHELF = 16'hFFFF;
  localparam logic [7:0]  WILD_SLOT  = 8'hFF;

  localparam logic [7:0] ST_READY   = 8'h40;
  localparam logic [7:0] ST_ERR     = 8'h01;
  localparam logic [7:0] ST_IO_FAIL = 8'h21;
  localparam logic [7:0] ER_NONE    = 8'h00;
  localparam logic [7:0] ER_ABORTED = 8'h04;
  localparam logic [7:0] ER_IDNF    = 8'h10;
  localparam logic [7:0] ER_IO_FAIL = 8'h44;

  localparam logic [16:0] IDENTIFY_BYTES = 17'd512;
  localparam int          SECTOR_SHIFT   = 9;

  typedef enum logic [1:0] {
    ACT_REPLY = 2'd0,
    ACT_ISSUE = 2'd1,
    ACT_DONE  = 2'd2
  } action_t;

  typedef struct packed {
    logic        cmd;
    logic [15:0] target_shelf;
    logic [7:0]  target_slot;
    logic [7:0]  ata_opcode;
    logic [47:0] lba_raw;
    logic [7:0]  sector_count;
    logic [3:0]  done_slot;
    logic        io_ok;
  } in_t;

  typedef struct packed {
    action_t     action;
    logic [7:0]  status_byte;
    logic [7:0]  error_byte;
    logic [3:0]  slot_index;
    logic        is_write;
    logic [47:0] start_sector;
    logic [7:0]  sectors;
    logic [16:0] payload_bytes;
  } out_t;

  typedef struct packed {
    logic [47:0] capacity_sectors;
    logic [15:0] shelf_address;
    logic [7:0]  slot_address;
  } cfg_t;

  // What is remembered per request slot while its I/O is outstanding.
  typedef struct packed {
    logic       is_read;
    logic [7:0] sector_count;
  } slot_info_t;

endpackage

`default_nettype wire

// ----- hw/rtl/aoe_cfe_ram.sv -----
`default_nettype none

module aoe_cfe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ----- hw/rtl/aoe_cfe_regs.sv -----
`default_nettype none

module aoe_cfe_regs (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [aoe_cfe_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [aoe_cfe_pkg::CFG_DATA_W-1:0] pwdata,
  output logic      [aoe_cfe_pkg::CFG_DATA_W-1:0] prdata,
  output logic                                    pready,
  output aoe_cfe_pkg::cfg_t                       cfg
);

  import aoe_cfe_pkg::*;

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  logic [1:0] reg_idx;
  logic       wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[CFG_ADDR_W-1:3];
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_CAPACITY: cfg_nxt.capacity_sectors = pwdata[47:0];
        REG_SHELF:    cfg_nxt.shelf_address    = pwdata[15:0];
        REG_SLOT:     cfg_nxt.slot_address     = pwdata[7:0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_CAPACITY: prdata = {16'd0, cfg_r.capacity_sectors};
      REG_SHELF:    prdata = {48'd0, cfg_r.shelf_address};
      REG_SLOT:     prdata = {56'd0, cfg_r.slot_address};
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ----- hw/rtl/aoe_cfe_decode.sv -----
`default_nettype none

module aoe_cfe_decode #(
  parameter int SLOT_COUNT = aoe_cfe_pkg::SLOT_COUNT_DEF,
  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
  input  wire aoe_cfe_pkg::in_t          item,
  input  wire aoe_cfe_pkg::cfg_t         cfg,
  input  wire logic [SLOT_COUNT-1:0]     busy,
  input  wire aoe_cfe_pkg::slot_info_t   slot_rd,
  output logic                           res_valid,
  output aoe_cfe_pkg::out_t              res,
  output logic      [SLOT_COUNT-1:0]     busy_nxt,
  output logic                           wr_en,
  output logic      [IDX_W-1:0]          wr_idx,
  output aoe_cfe_pkg::slot_info_t        wr_data
);

  import aoe_cfe_pkg::*;

  logic [IDX_W-1:0] done_idx;
  logic             done_live;
  logic             addr_match;
  logic             free_found;
  logic [IDX_W-1:0] free_idx;
  logic [47:0]      lba_m;
  logic             out_of_range;
  logic             is_wr;

  assign done_idx  = IDX_W'(item.done_slot);
  assign done_live = (32'(item.done_slot) < SLOT_COUNT) && busy[done_idx];

  assign addr_match =
      (item.target_shelf == cfg.shelf_address || item.target_shelf == WILD_SHELF) &&
      (item.target_slot  == cfg.slot_address  || item.target_slot  == WILD_SLOT);

  // Plain read and write only carry a 28-bit LBA.
  assign lba_m = (item.ata_opcode == OP_READ || item.ata_opcode == OP_WRITE) ?
                 {20'd0, item.lba_raw[27:0]} : item.lba_raw;
  assign is_wr = (item.ata_opcode == OP_WRITE || item.ata_opcode == OP_WRITE_EXT);

  assign out_of_range = ({1'b0, lba_m} + {41'd0, item.sector_count}) >
                        {1'b0, cfg.capacity_sectors};

  // Lowest free slot wins.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!busy[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  always_comb begin
    res_valid            = 1'b0;
    res                  = '0;
    busy_nxt             = busy;
    wr_en                = 1'b0;
    wr_idx               = free_idx;
    wr_data.is_read      = !is_wr;
    wr_data.sector_count = item.sector_count;

    if (item.cmd) begin
      if (done_live) begin
        busy_nxt[done_idx] = 1'b0;
        res_valid          = 1'b1;
        res.action         = ACT_DONE;
        res.slot_index     = item.done_slot;
        res.is_write       = !slot_rd.is_read;
        res.sectors        = slot_rd.sector_count;
        if (item.io_ok) begin
          res.status_byte = ST_READY;
          res.error_byte  = ER_NONE;
          if (slot_rd.is_read) begin
            res.payload_bytes = {slot_rd.sector_count, SECTOR_SHIFT'(0)};
          end
        end else begin
          res.status_byte = ST_IO_FAIL;
          res.error_byte  = ER_IO_FAIL;
        end
      end
    end else if (addr_match) begin
      unique case (item.ata_opcode)
        OP_READ, OP_READ_EXT, OP_WRITE, OP_WRITE_EXT: begin
          if (out_of_range) begin
            res_valid       = 1'b1;
            res.action      = ACT_REPLY;
            res.status_byte = ST_ERR;
            res.error_byte  = ER_IDNF;
          end else if (free_found) begin
            // With no free slot the request is dropped silently.
            res_valid          = 1'b1;
            res.action         = ACT_ISSUE;
            res.slot_index     = 4'(free_idx);
            res.is_write       = is_wr;
            res.start_sector   = lba_m;
            res.sectors        = item.sector_count;
            busy_nxt[free_idx] = 1'b1;
            wr_en              = 1'b1;
          end
        end
        OP_IDENTIFY: begin
          res_valid         = 1'b1;
          res.action        = ACT_REPLY;
          res.status_byte   = ST_READY;
          res.payload_bytes = IDENTIFY_BYTES;
        end
        OP_FLUSH: begin
          res_valid       = 1'b1;
          res.action      = ACT_REPLY;
          res.status_byte = ST_READY;
        end
        default: begin
          res_valid       = 1'b1;
          res.action      = ACT_REPLY;
          res.status_byte = ST_ERR;
          res.error_byte  = ER_ABORTED;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/ata_over_ethernet_command_frontend_core.sv -----
`default_nettype none

// Each request passes through the input register and then the result register.
// Throughput: one request per cycle unless out_stall holds the result; the input register, the
// slot state update and the result register all advance together, and the result register
// frees while it is taken. Reset (rst_n low, synchronous) empties both stages, frees every
// slot and clears the configuration registers; it needs no clearing pass.
module ata_over_ethernet_command_frontend_core #(
  parameter int SLOT_COUNT = aoe_cfe_pkg::SLOT_COUNT_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire aoe_cfe_pkg::in_t                   in_payload,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output aoe_cfe_pkg::out_t                       out_payload,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [aoe_cfe_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [aoe_cfe_pkg::CFG_DATA_W-1:0] pwdata,
  output logic      [aoe_cfe_pkg::CFG_DATA_W-1:0] prdata,
  output logic                                    pready
);

  import aoe_cfe_pkg::*;

  localparam int IDX_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int INFO_W = $bits(slot_info_t);

  cfg_t                  cfg;
  logic                  s1_valid_r;
  logic                  s1_valid_nxt;
  in_t                   s1_item_r;
  logic                  out_valid_r;
  logic                  out_valid_nxt;
  out_t                  out_data_r;
  logic [SLOT_COUNT-1:0] busy_r;
  logic [SLOT_COUNT-1:0] busy_nxt;
  logic                  res_valid;
  out_t                  res;
  logic                  dec_wr_en;
  logic [IDX_W-1:0]      dec_wr_idx;
  slot_info_t            dec_wr_data;
  logic                  out_ready;
  logic                  s1_retire;
  logic                  in_accept;
  logic                  ram_we;
  logic [IDX_W-1:0]      ram_raddr;
  logic [INFO_W-1:0]     ram_rdata;
  logic                  fwd_hit_r;
  slot_info_t            fwd_data_r;
  slot_info_t            slot_rd;

  aoe_cfe_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign out_ready = !out_valid_r || !out_stall;
  assign s1_retire = s1_valid_r && (!res_valid || out_ready);
  assign in_stall  = s1_valid_r && !s1_retire;
  assign in_accept = in_valid && !in_stall;

  // The slot table is read as the request enters, so its data lines up with
  // the input register. A slot written at that same edge is forwarded.
  assign ram_we    = s1_retire && dec_wr_en;
  assign ram_raddr = IDX_W'(in_payload.done_slot);

  aoe_cfe_ram #(
    .WIDTH (INFO_W),
    .DEPTH (SLOT_COUNT)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (dec_wr_idx),
    .wdata (dec_wr_data),
    .re    (in_accept),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item_r  <= in_payload;
      fwd_hit_r  <= ram_we && (dec_wr_idx == ram_raddr);
      fwd_data_r <= dec_wr_data;
    end
  end

  assign slot_rd = fwd_hit_r ? fwd_data_r : slot_info_t'(ram_rdata);

  aoe_cfe_decode #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_decode (
    .item      (s1_item_r),
    .cfg       (cfg),
    .busy      (busy_r),
    .slot_rd   (slot_rd),
    .res_valid (res_valid),
    .res       (res),
    .busy_nxt  (busy_nxt),
    .wr_en     (dec_wr_en),
    .wr_idx    (dec_wr_idx),
    .wr_data   (dec_wr_data)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_retire) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = s1_retire && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      busy_r      <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_retire) begin
        busy_r <= busy_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && s1_retire && res_valid) begin
      out_data_r <= res;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_payload = out_data_r;

endmodule

`default_nettype wire

// ----- sim/aoe_cfe_checker.sv -----
`default_nettype none

module aoe_cfe_checker (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  input  wire logic                               in_stall,
  input  wire aoe_cfe_pkg::in_t                   in_payload,
  input  wire logic                               out_valid,
  input  wire logic                               out_stall,
  input  wire aoe_cfe_pkg::out_t                  out_payload,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic                               pready,
  input  wire logic [aoe_cfe_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [aoe_cfe_pkg::CFG_DATA_W-1:0] pwdata,
  output int                                      mismatches,
  output int                                      replies_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import aoe_cfe_pkg::*;

  localparam int SLOTS = SLOT_COUNT_DEF;

  cfg_t             target_cfg;
  logic [SLOTS-1:0] slot_busy;
  slot_info_t       slot_info [SLOTS];
  out_t             replies_due [$];
  int               fail_count = 0;

  function automatic string describe(input out_t r);
    return $sformatf("act=%0d st=%02h er=%02h slot=%0d wr=%0b lba=%012h cnt=%0d bytes=%0d",
                     r.action, r.status_byte, r.error_byte, r.slot_index, r.is_write,
                     r.start_sector, r.sectors, r.payload_bytes);
  endfunction

  // Works out the reply, if any, that one accepted request causes.
  function automatic void predict_frontend(input in_t req);
    out_t        rep;
    logic [47:0] lba;
    logic        answered;
    int          i;
    rep = '0;
    answered = 1'b0;
    lba = req.lba_raw;
    if (req.cmd) begin
      if (int'(req.done_slot) >= SLOTS || !slot_busy[req.done_slot]) return;
      slot_busy[req.done_slot] = 1'b0;
      rep.action = ACT_DONE;
      rep.slot_index = req.done_slot;
      rep.is_write = !slot_info[req.done_slot].is_read;
      rep.sectors = slot_info[req.done_slot].sector_count;
      if (req.io_ok) begin
        rep.status_byte = ST_READY;
        rep.error_byte = ER_NONE;
        if (slot_info[req.done_slot].is_read)
          rep.payload_bytes = 17'(slot_info[req.done_slot].sector_count) << SECTOR_SHIFT;
      end else begin
        rep.status_byte = ST_IO_FAIL;
        rep.error_byte = ER_IO_FAIL;
      end
      replies_due.push_back(rep);
      return;
    end

    if ((req.target_shelf != target_cfg.shelf_address && req.target_shelf != WILD_SHELF) ||
        (req.target_slot != target_cfg.slot_address && req.target_slot != WILD_SLOT))
      return;

    rep.action = ACT_REPLY;
    case (req.ata_opcode)
      OP_READ, OP_WRITE: lba = {20'h0, req.lba_raw[27:0]};
      OP_READ_EXT, OP_WRITE_EXT: lba = req.lba_raw;
      OP_IDENTIFY: begin
        rep.status_byte = ST_READY;
        rep.payload_bytes = IDENTIFY_BYTES;
        answered = 1'b1;
      end
      OP_FLUSH: begin
        rep.status_byte = ST_READY;
        answered = 1'b1;
      end
      default: begin
        rep.status_byte = ST_ERR;
        rep.error_byte = ER_ABORTED;
        answered = 1'b1;
      end
    endcase

    // The range check must not wrap, so it is done one bit wider.
    if (!answered && ({1'b0, lba} + 49'(req.sector_count) > {1'b0, target_cfg.capacity_sectors}))
    begin
      rep.status_byte = ST_ERR;
      rep.error_byte = ER_IDNF;
      answered = 1'b1;
    end
    if (answered) begin
      replies_due.push_back(rep);
      return;
    end

    // A request that finds every slot taken is dropped without a reply.
    for (i = 0; i < SLOTS; i++) begin
      if (!slot_busy[i]) begin
        slot_busy[i] = 1'b1;
        slot_info[i].is_read = (req.ata_opcode == OP_READ || req.ata_opcode == OP_READ_EXT);
        slot_info[i].sector_count = req.sector_count;
        rep.action = ACT_ISSUE;
        rep.slot_index = 4'(i);
        rep.is_write = !slot_info[i].is_read;
        rep.start_sector = lba;
        rep.sectors = req.sector_count;
        replies_due.push_back(rep);
        return;
      end
    end
  endfunction

  always @(posedge clk) begin
    out_t got;
    out_t want;
    if (!rst_n) begin
      target_cfg = '0;
      slot_busy = '0;
      replies_due.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[CFG_ADDR_W-1:3])
          REG_CAPACITY: target_cfg.capacity_sectors = pwdata[47:0];
          REG_SHELF:    target_cfg.shelf_address = pwdata[15:0];
          REG_SLOT:     target_cfg.slot_address = pwdata[7:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        got = out_payload;
        if (replies_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t unexpected reply: %s", $realtime, describe(got));
        end else begin
          want = replies_due.pop_front();
          if (got.action !== want.action || got.status_byte !== want.status_byte ||
              got.error_byte !== want.error_byte || got.slot_index !== want.slot_index ||
              got.is_write !== want.is_write || got.start_sector !== want.start_sector ||
              got.sectors !== want.sectors || got.payload_bytes !== want.payload_bytes) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("%0t reply mismatch", $realtime);
              $display("  expected %s", describe(want));
              $display("  actual   %s", describe(got));
            end
          end
        end
      end
      if (in_valid && !in_stall)
        predict_frontend(in_payload);
    end
    mismatches <= fail_count;
    replies_pending <= replies_due.size();
  end

endmodule

`default_nettype wire

// ----- sim/tb_top.sv -----
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import aoe_cfe_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int          HOLD_CYCLES = 300;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_t                   in_payload = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_t                  out_payload;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  int          mismatches;
  int          replies_pending;
  int          gap_pct = 0;
  int          stall_pct = 0;
  logic        hold_off = 1'b0;
  logic        pressure_go = 1'b0;
  int unsigned cycles = 0;

  // Slots seen issued and not yet completed by the stimulus.
  logic [3:0]  issued_slots [$];
  logic [47:0] cap_now;
  logic [15:0] shelf_now;
  logic [7:0]  slot_now;

  ata_over_ethernet_command_frontend_core u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_payload  (in_payload),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_payload (out_payload),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  aoe_cfe_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_payload      (in_payload),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_payload     (out_payload),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .pready          (pready),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .mismatches      (mismatches),
    .replies_pending (replies_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  always @(posedge clk)
    out_stall <= hold_off || ($urandom_range(0, 99) < stall_pct);

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall && out_payload.action == ACT_ISSUE)
      issued_slots.push_back(out_payload.slot_index);
  end

  // The long hold-off lets the block fill up while requests keep coming.
  initial begin
    wait (pressure_go);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  function automatic in_t noise_item();
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    return in_t'(raw[$bits(in_t)-1:0]);
  endfunction

  function automatic in_t ata_request(input logic [7:0] op, input logic [15:0] shelf,
                                      input logic [7:0] slot, input logic [47:0] lba,
                                      input logic [7:0] cnt);
    in_t r;
    r = noise_item();
    r.cmd = 1'b0;
    r.target_shelf = shelf;
    r.target_slot = slot;
    r.ata_opcode = op;
    r.lba_raw = lba;
    r.sector_count = cnt;
    return r;
  endfunction

  function automatic in_t io_done(input logic [3:0] slot, input logic ok);
    in_t r;
    r = noise_item();
    r.cmd = 1'b1;
    r.done_slot = slot;
    r.io_ok = ok;
    return r;
  endfunction

  // Mostly addressed reads and writes that land inside the disk, with some
  // wildcards, mismatches, boundary misses and other opcodes mixed in.
  function automatic in_t gen_request();
    logic [7:0]  op;
    logic [7:0]  cnt;
    logic [15:0] shelf;
    logic [7:0]  slot;
    logic [47:0] room;
    logic [47:0] lba;
    logic [63:0] wide;
    logic        plain;
    int unsigned pick;
    shelf = shelf_now;
    slot = slot_now;
    pick = $urandom_range(0, 19);
    if (pick == 0) shelf = 16'($urandom);
    else if (pick == 1) slot = 8'($urandom);
    else if (pick < 5) shelf = WILD_SHELF;
    else if (pick < 7) slot = WILD_SLOT;
    else if (pick == 7) begin
      shelf = WILD_SHELF;
      slot = WILD_SLOT;
    end
    pick = $urandom_range(0, 99);
    if (pick < 80) begin
      case ($urandom_range(0, 3))
        0: op = OP_READ;
        1: op = OP_READ_EXT;
        2: op = OP_WRITE;
        default: op = OP_WRITE_EXT;
      endcase
    end else if (pick < 87) begin
      op = OP_IDENTIFY;
    end else if (pick < 93) begin
      op = OP_FLUSH;
    end else begin
      op = 8'($urandom);
    end
    cnt = 8'($urandom);
    if (cap_now < 48'(cnt)) cnt = cap_now[7:0];
    room = cap_now - 48'(cnt);
    plain = (op == OP_READ || op == OP_WRITE);
    if (plain && room > 48'h0FFF_FFFF) room = 48'h0FFF_FFFF;
    if ($urandom_range(0, 9) == 0) begin
      lba = room + 48'($urandom_range(0, 1));
    end else begin
      wide = {$urandom, $urandom};
      lba = 48'(wide % (64'(room) + 64'd1));
    end
    if (plain) lba[47:28] = 20'($urandom);
    return ata_request(op, shelf, slot, lba, cnt);
  endfunction

  task automatic send(input in_t item);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_payload <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (replies_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Leaves psel high so that back-to-back writes need no second assignment.
  task automatic write_reg(input logic [1:0] idx, input logic [CFG_DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
  endtask

  task automatic set_config(input logic [47:0] cap, input logic [15:0] shelf,
                            input logic [7:0] slot);
    cap_now = cap;
    shelf_now = shelf;
    slot_now = slot;
    write_reg(REG_CAPACITY, 64'(cap));
    write_reg(REG_SHELF, 64'(shelf));
    write_reg(REG_SLOT, 64'(slot));
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // Each run picks a completion share of 0, 30, 60 or 90 percent, so the slots fill and drain.
  task automatic run_random(input int n);
    int          left;
    int          run_len;
    int unsigned done_pct;
    int unsigned idx;
    logic [3:0]  slot;
    left = n;
    while (left > 0) begin
      run_len = $urandom_range(1, 24);
      done_pct = 30 * $urandom_range(0, 3);
      while (run_len > 0 && left > 0) begin
        if ($urandom_range(0, 99) < 8) begin
          send(noise_item());
        end else if (issued_slots.size() > 0 && $urandom_range(0, 99) < done_pct) begin
          idx = $urandom_range(0, issued_slots.size() - 1);
          slot = issued_slots[idx];
          issued_slots.delete(idx);
          send(io_done(slot, $urandom_range(0, 3) != 0));
        end else begin
          send(gen_request());
        end
        run_len--;
        left--;
      end
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_config(48'd1000, 16'h1234, 8'h56);
    gap_pct <= 21;
    stall_pct <= 67;
    send(ata_request(OP_IDENTIFY, 16'h1234, 8'h56, 48'd0, 8'd0));
    send(ata_request(OP_FLUSH, WILD_SHELF, WILD_SLOT, 48'd0, 8'd0));
    send(ata_request(8'h00, 16'h1234, 8'h56, 48'd0, 8'd0));
    send(ata_request(8'hFF, WILD_SHELF, 8'h56, 48'd0, 8'd0));
    send(ata_request(OP_IDENTIFY, 16'h1235, 8'h56, 48'd0, 8'd0));
    send(ata_request(OP_IDENTIFY, 16'h1234, 8'h57, 48'd0, 8'd0));
    send(ata_request(OP_READ, 16'h1234, 8'h56, 48'd0, 8'd0));
    send(ata_request(OP_WRITE, 16'h1234, WILD_SLOT, 48'd999, 8'd1));
    send(ata_request(OP_WRITE_EXT, 16'h1234, 8'h56, 48'd900, 8'd101));
    // Plain read: the upper LBA bits vanish, so this one fits.
    send(ata_request(OP_READ, 16'h1234, 8'h56, 48'hFFFF_F000_0005, 8'd255));
    send(ata_request(OP_READ_EXT, 16'h1234, 8'h56, 48'hFFFF_FFFF_FFFF, 8'd255));
    send(ata_request(OP_READ_EXT, WILD_SHELF, 8'h56, 48'd1000, 8'd0));
    send(io_done(4'd0, 1'b1));
    send(io_done(4'd2, 1'b1));
    send(io_done(4'd1, 1'b0));
    send(io_done(4'd0, 1'b1));
    send(io_done(4'd15, 1'b1));
    run_random(500);
    settle();

    gap_pct <= 67;
    stall_pct <= 21;
    set_config(48'hFFFF_FFFF_FFFF, 16'hFFFF, 8'hFF);
    run_random(600);
    settle();

    gap_pct <= 0;
    stall_pct <= 0;
    set_config(48'd0, 16'h0000, 8'h00);
    run_random(200);
    settle();

    set_config({16'($urandom), 32'($urandom)}, 16'($urandom), 8'($urandom));
    pressure_go <= 1'b1;
    run_random(700);
    settle();

    if (mismatches == 0 && replies_pending == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

endmodule

`default_nettype wire
